/* src/distance_falloff_curve_assert.svh */
// Assertion helpers, clocked on aclk and held off during reset.
`ifndef DISTANCE_FALLOFF_CURVE_ASSERT_SVH
`define DISTANCE_FALLOFF_CURVE_ASSERT_SVH

`define DFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define DFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dfc_pkg.sv */
`default_nettype none
package dfc_pkg;

    typedef enum logic [1:0] {
        REG_NEAR = 2'b00,
        REG_MID  = 2'b01,
        REG_FAR  = 2'b10
    } region_t;

    typedef struct packed {
        logic    valid;
        region_t region;
    } dfc_ctl_t;

    localparam logic [1:0] CFG_NEAR  = 2'd0;
    localparam logic [1:0] CFG_FAR   = 2'd1;
    localparam logic [1:0] CFG_CURVE = 2'd2;
    localparam logic [1:0] CFG_ATTEN = 2'd3;

    localparam logic [23:0] NEAR_RST  = 24'd9216;
    localparam logic [23:0] FAR_RST   = 24'd92160;
    localparam logic [15:0] CURVE_RST = 16'd0;
    localparam logic [23:0] ATTEN_RST = 24'd92160;

    // 1.1 and 1.0 in Q4.12
    localparam logic signed [16:0] EXP_BIAS  = 17'sd4506;
    localparam logic signed [15:0] CURVE_MAX = 16'sd4096;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bval;
        v    = v_in;
        res  = 64'd0;
        bval = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bval > v) bval = bval >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (bval != 64'd0) begin
                if (v >= res + bval) begin
                    v   = v - (res + bval);
                    res = (res >> 1) + bval;
                end else begin
                    res = res >> 1;
                end
                bval = bval >> 2;
            end
        end
        return res;
    endfunction

    // log2(1 + idx/2^bits) in Q0.16, by repeated squaring
    function automatic logic [16:0] log_entry(input int bits, input int idx);
        logic [63:0] y;
        logic [16:0] r;
        logic [17:0] rr;
        if (idx >= (1 << bits)) return 17'd65536;
        y = (64'd1 << 30) + (64'(idx) << (30 - bits));
        r = 17'd0;
        for (int k = 0; k < 17; k++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd2 << 30)) begin
                y    = y >> 1;
                r[0] = 1'b1;
            end
        end
        rr = {1'b0, r} + 18'd1;
        return rr[17:1];
    endfunction

    // 2^(-idx/2^bits) in Q0.16, from square roots of one half in Q0.30
    function automatic logic [16:0] exp_entry(input int bits, input int idx);
        logic [63:0] roots [0:12];
        logic [63:0] s;
        logic [63:0] prod;
        logic [63:0] tmp;
        if (idx >= (1 << bits)) return 17'd32768;
        s        = 64'd1 << 29;
        roots[0] = s;
        for (int k = 1; k <= bits; k++) begin
            s        = isqrt64(s << 30);
            roots[k] = s;
        end
        prod = 64'd1 << 30;
        for (int k = 0; k < bits; k++) begin
            if (((idx >> k) & 1) != 0)
                prod = (prod * roots[bits - k] + (64'd1 << 29)) >> 30;
        end
        tmp = prod + 64'd8192;
        return tmp[30:14];
    endfunction

endpackage
`default_nettype wire

/* src/dfc_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per stage: x = (rem << 16) / span.
module dfc_div
    import dfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire dfc_ctl_t    in_ctl,
    input  wire logic [23:0] in_rem,
    input  wire logic [23:0] span,
    output dfc_ctl_t         out_ctl,
    output logic      [16:0] out_x
);

    localparam int STAGES = 17;

    dfc_ctl_t    ctl_reg [0:STAGES-1];
    logic [23:0] r_reg   [0:STAGES-1];
    logic [16:0] q_reg   [0:STAGES-1];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        dfc_ctl_t    ctl_in;
        logic [23:0] r_in;
        logic [16:0] q_in;
        logic [24:0] t;
        logic [24:0] diff;
        logic        ge;
        logic [23:0] r_next;
        logic [16:0] q_next;

        if (k == 0) begin : g_first
            assign ctl_in = in_ctl;
            assign r_in   = in_rem;
            assign q_in   = '0;
            assign t      = {1'b0, r_in};
        end else begin : g_rest
            assign ctl_in = ctl_reg[k-1];
            assign r_in   = r_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign t      = {r_in, 1'b0};
        end

        assign ge     = t >= {1'b0, span};
        assign diff   = t - {1'b0, span};
        assign r_next = ge ? diff[23:0] : t[23:0];
        assign q_next = {q_in[15:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k] <= '0;
            end else if (en) begin
                ctl_reg[k] <= ctl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k] <= r_next;
                q_reg[k] <= q_next;
            end
        end
    end

    assign out_ctl = ctl_reg[STAGES-1];
    assign out_x   = q_reg[STAGES-1];

endmodule
`default_nettype wire

/* src/dfc_pow.sv */
`default_nettype none
// x^e as exp2(-e * -log2 x), six stages.
module dfc_pow
    import dfc_pkg::*;
#(
    parameter int LOG_TABLE_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire dfc_ctl_t    in_ctl,
    input  wire logic [16:0] in_x,
    input  wire logic [15:0] expo,
    output dfc_ctl_t         out_ctl,
    output logic      [16:0] out_pw
);

    localparam int SEGS = 1 << LOG_TABLE_BITS;
    localparam int LB   = 15 - LOG_TABLE_BITS;
    localparam int EB   = 16 - LOG_TABLE_BITS;
    localparam int LW   = 17 + LB + 1;
    localparam int EW   = 17 + EB + 1;
    localparam int TI   = LOG_TABLE_BITS;

    logic [16:0] log_rom [0:SEGS];
    logic [16:0] exp_rom [0:SEGS];

    for (genvar g = 0; g <= SEGS; g++) begin : g_rom
        localparam logic [16:0] LV = log_entry(LOG_TABLE_BITS, g);
        localparam logic [16:0] EV = exp_entry(LOG_TABLE_BITS, g);
        assign log_rom[g] = LV;
        assign exp_rom[g] = EV;
    end

    // flags: x is zero, x is one, exponent result too large
    typedef struct packed {
        logic zero;
        logic full;
        logic big;
    } pw_flag_t;

    dfc_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
        end else if (en) begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
        end
    end

    // stage 1: normalize mantissa
    logic [3:0]    p_next;
    logic [15:0]   m_next;
    pw_flag_t      fl1_next;
    logic [3:0]    p1_reg;
    logic [TI-1:0] li_reg;
    logic [LB-1:0] lf_reg;
    pw_flag_t      fl1_reg;

    always_comb begin
        p_next = 4'd0;
        for (int b = 0; b < 16; b++) begin
            if (in_x[b]) p_next = 4'(b);
        end
    end

    assign m_next   = in_x[15:0] << (4'd15 - p_next);
    assign fl1_next = '{zero: (in_x == '0), full: in_x[16], big: 1'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg  <= p_next;
            li_reg  <= m_next[14:LB];
            lf_reg  <= m_next[LB-1:0];
            fl1_reg <= fl1_next;
        end
    end

    // stage 2: log2 interpolation
    logic [TI:0]   la_idx, lb_idx;
    logic [16:0]   la, lbv, ldiff, l_next;
    logic [LW-1:0] lprod;
    logic [LW-1:0] lfrac;
    logic [3:0]    p2_reg;
    logic [16:0]   l2_reg;
    pw_flag_t      fl2_reg;

    assign la_idx = {1'b0, li_reg};
    assign lb_idx = la_idx + (TI+1)'(1);
    assign la     = log_rom[la_idx];
    assign lbv    = log_rom[lb_idx];
    assign ldiff  = lbv - la;
    assign lprod  = LW'(ldiff) * LW'(lf_reg) + (LW'(1) << (LB - 1));
    assign lfrac  = lprod >> LB;
    assign l_next = la + lfrac[16:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_reg  <= p1_reg;
            l2_reg  <= l_next;
            fl2_reg <= fl1_reg;
        end
    end

    // stage 3: -log2 x times exponent
    logic [4:0]  whole;
    logic [20:0] big_l;
    logic [36:0] mul3_reg;
    pw_flag_t    fl3_reg;

    assign whole = 5'd16 - {1'b0, p2_reg};
    assign big_l = {whole, 16'd0} - {4'd0, l2_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            mul3_reg <= 37'(big_l) * 37'(expo);
            fl3_reg  <= fl2_reg;
        end
    end

    // stage 4: round to Q.16, split shift and fraction
    logic [37:0]   sum4;
    logic [25:0]   prod4;
    pw_flag_t      fl4_next;
    logic [4:0]    n4_reg;
    logic [TI-1:0] ei_reg;
    logic [EB-1:0] ef_reg;
    pw_flag_t      fl4_reg;

    assign sum4     = {1'b0, mul3_reg} + 38'd2048;
    assign prod4    = sum4[37:12];
    assign fl4_next = '{zero: fl3_reg.zero, full: fl3_reg.full,
                        big: (prod4[25:16] >= 10'd17)};

    always_ff @(posedge aclk) begin
        if (en) begin
            n4_reg  <= prod4[20:16];
            ei_reg  <= prod4[15:EB];
            ef_reg  <= prod4[EB-1:0];
            fl4_reg <= fl4_next;
        end
    end

    // stage 5: exp2 interpolation
    logic [TI:0]   ea_idx, eb_idx;
    logic [16:0]   ea, ebv, ediff;
    logic [EW-1:0] eprod, efrac;
    logic [16:0]   v5_reg;
    logic [4:0]    n5_reg;
    pw_flag_t      fl5_reg;

    assign ea_idx = {1'b0, ei_reg};
    assign eb_idx = ea_idx + (TI+1)'(1);
    assign ea     = exp_rom[ea_idx];
    assign ebv    = exp_rom[eb_idx];
    assign ediff  = ea - ebv;
    assign eprod  = EW'(ediff) * EW'(ef_reg) + (EW'(1) << (EB - 1));
    assign efrac  = eprod >> EB;

    always_ff @(posedge aclk) begin
        if (en) begin
            v5_reg  <= ea - efrac[16:0];
            n5_reg  <= n4_reg;
            fl5_reg <= fl4_reg;
        end
    end

    // stage 6: rounding right shift by the integer part
    logic [17:0] rnd6, sum6, sh6;
    logic [16:0] pw_next;
    logic [16:0] pw6_reg;

    assign rnd6 = (n5_reg == 5'd0) ? 18'd0 : (18'd1 << (n5_reg - 5'd1));
    assign sum6 = {1'b0, v5_reg} + rnd6;
    assign sh6  = sum6 >> n5_reg;

    always_comb begin
        if (fl5_reg.full) begin
            pw_next = 17'd65536;
        end else if (fl5_reg.zero || fl5_reg.big) begin
            pw_next = 17'd0;
        end else begin
            pw_next = sh6[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pw6_reg <= pw_next;
        end
    end

    assign out_ctl = ctl6_reg;
    assign out_pw  = pw6_reg;

endmodule
`default_nettype wire

/* src/distance_falloff_curve.sv */
// Pipeline: 1 range stage, 17 divider stages, 6 power stages, 1 gain
// multiply, 1 output register.
// Throughput: one item per cycle; a stalled output freezes the whole pipe.
// Reset (aresetn low, synchronous): pipeline emptied, registers return to
// near 36.0, far 360.0, curve 0, attenuation 360.0.
`default_nettype none
`include "distance_falloff_curve_assert.svh"
module distance_falloff_curve
    import dfc_pkg::*;
#(
    parameter int LOG_TABLE_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [23:0] s_distance,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [23:0] m_gain
);

    logic [23:0] near_reg, far_reg, atten_reg;
    logic [15:0] curve_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg  <= NEAR_RST;
            far_reg   <= FAR_RST;
            curve_reg <= CURVE_RST;
            atten_reg <= ATTEN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NEAR:  near_reg  <= cfg_data;
                CFG_FAR:   far_reg   <= cfg_data;
                CFG_CURVE: curve_reg <= cfg_data[15:0];
                CFG_ATTEN: atten_reg <= cfg_data;
            endcase
        end
    end

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // range check
    logic [23:0]       hi, span, rem_next;
    region_t           region_next;
    dfc_ctl_t          ctl0_reg;
    logic [23:0]       rem0_reg;
    logic signed [15:0] curve_c;
    logic signed [16:0] expo_s;
    logic [15:0]       expo;

    assign hi       = (far_reg > near_reg) ? far_reg : near_reg;
    assign span     = hi - near_reg;
    assign rem_next = s_distance - near_reg;

    always_comb begin
        if (s_distance <= near_reg) begin
            region_next = REG_NEAR;
        end else if (s_distance > hi) begin
            region_next = REG_FAR;
        end else begin
            region_next = REG_MID;
        end
    end

    assign curve_c = ($signed(curve_reg) > CURVE_MAX) ? CURVE_MAX : $signed(curve_reg);
    assign expo_s  = EXP_BIAS - 17'(curve_c);
    assign expo    = expo_s[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl0_reg <= '0;
        end else if (en) begin
            ctl0_reg <= '{valid: s_valid, region: region_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem0_reg <= rem_next;
        end
    end

    dfc_ctl_t    div_ctl, pow_ctl;
    logic [16:0] div_x, pow_pw;

    dfc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (ctl0_reg),
        .in_rem  (rem0_reg),
        .span    (span),
        .out_ctl (div_ctl),
        .out_x   (div_x)
    );

    dfc_pow #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_pow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (div_ctl),
        .in_x    (div_x),
        .expo    (expo),
        .out_ctl (pow_ctl),
        .out_pw  (pow_pw)
    );

    // gain multiply
    dfc_ctl_t    ctlm_reg;
    logic [40:0] mulm_reg;
    logic [16:0] one_minus;

    assign one_minus = 17'd65536 - pow_pw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctlm_reg <= '0;
        end else if (en) begin
            ctlm_reg <= pow_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mulm_reg <= 41'(atten_reg) * 41'(one_minus);
        end
    end

    // output register
    dfc_ctl_t    out_ctl_reg;
    logic [23:0] gain_reg, gain_next;
    logic [40:0] gain_rnd;

    assign gain_rnd = mulm_reg + 41'd32768;

    always_comb begin
        unique case (ctlm_reg.region)
            REG_NEAR: gain_next = atten_reg;
            REG_FAR:  gain_next = 24'd0;
            REG_MID:  gain_next = gain_rnd[39:16];
            default:  gain_next = 24'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_ctl_reg <= '0;
        end else if (en) begin
            out_ctl_reg <= ctlm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gain_reg <= gain_next;
        end
    end

    assign m_valid = out_ctl_reg.valid;
    assign m_gain  = gain_reg;

    `DFC_ASSERT_IMP(a_gain_le_atten, m_valid, m_gain <= atten_reg, "gain above attenuation")
    `DFC_ASSERT_IMP(a_far_zero, m_valid && (out_ctl_reg.region == REG_FAR), m_gain == 24'd0, "far item nonzero")
    `DFC_ASSERT_IMP(a_stall_src, !s_ready, m_valid && !m_ready, "input blocked without output stall")

endmodule
`default_nettype wire

/* dv/gain_checker.sv */
module gain_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [23:0] s_distance,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [23:0] m_gain,
    output int               fail_count,
    output int               pending
);
    import dfc_pkg::*;

    localparam int TBITS = 8;
    localparam int SEGN = 1 << TBITS;

    logic [23:0] near_q, far_q, atten_q;
    logic signed [15:0] curve_q;
    logic [31:0] log_lut [0:SEGN];
    logic [31:0] exp_lut [0:SEGN];
    logic [23:0] gain_q [$];

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v_in);
        logic [63:0] v, res, b;
        v = v_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    initial begin
        logic [63:0] y, s, prod;
        logic [63:0] roots [0:TBITS];
        logic [31:0] r;
        for (int i = 0; i < SEGN; i++) begin
            y = (64'd1 << 30) + (64'(i) << (30 - TBITS));
            r = 0;
            for (int k = 0; k < 17; k++) begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= (64'd2 << 30)) begin
                    y = y >> 1;
                    r[0] = 1'b1;
                end
            end
            log_lut[i] = (r + 1) >> 1;
        end
        log_lut[SEGN] = 65536;
        s = 64'd1 << 29;
        roots[0] = s;
        for (int k = 1; k <= TBITS; k++) begin
            s = sqrt_floor(s << 30);
            roots[k] = s;
        end
        for (int i = 0; i < SEGN; i++) begin
            prod = 64'd1 << 30;
            for (int k = 0; k < TBITS; k++)
                if ((i >> k) & 1) prod = (prod * roots[TBITS - k] + (64'd1 << 29)) >> 30;
            exp_lut[i] = 32'((prod + 64'd8192) >> 14);
        end
        exp_lut[SEGN] = 32768;
    end

    // x^e, x in Q0.16 (1..65535), e in Q4.12
    function automatic logic [31:0] pow_q16(input logic [31:0] x, input logic [31:0] e);
        int lb, eb, p;
        logic [31:0] m, f, i, rem, l, g, n, v;
        logic [63:0] lg, prod;
        lb = 15 - TBITS;
        eb = 16 - TBITS;
        p = 15;
        while (p > 0 && x[p] == 1'b0) p--;
        m = x << (15 - p);
        f = m - 32768;
        i = f >> lb;
        rem = f & ((32'd1 << lb) - 1);
        l = log_lut[i] + (((log_lut[i+1] - log_lut[i]) * rem + (32'd1 << (lb - 1))) >> lb);
        lg = 64'(16 - p) * 64'd65536 - 64'(l);
        prod = (lg * 64'(e) + 64'd2048) >> 12;
        if ((prod >> 16) >= 17) return 0;
        n = 32'(prod >> 16);
        g = 32'(prod & 64'hFFFF);
        i = g >> eb;
        rem = g & ((32'd1 << eb) - 1);
        v = exp_lut[i] - (((exp_lut[i] - exp_lut[i+1]) * rem + (32'd1 << (eb - 1))) >> eb);
        if (n == 0) return v;
        return (v + (32'd1 << (n - 1))) >> n;
    endfunction

    function automatic logic [23:0] falloff_gain(input logic [23:0] d);
        logic [23:0] hi;
        logic [63:0] span;
        logic [31:0] x, e, pw;
        logic signed [31:0] c;
        hi = (far_q > near_q) ? far_q : near_q;
        if (d <= near_q) return atten_q;
        if (d > hi) return 0;
        span = 64'(hi - near_q);
        x = 32'((64'(d - near_q) << 16) / span);
        c = (curve_q > CURVE_MAX) ? 32'sd4096 : 32'(curve_q);
        e = 32'(32'sd4506 - c);
        if (x == 0) pw = 0;
        else if (x >= 65536) pw = 65536;
        else pw = pow_q16(x, e);
        return 24'((64'(atten_q) * 64'(65536 - pw) + 64'd32768) >> 16);
    endfunction

    assign pending = gain_q.size();

    always @(posedge aclk) begin
        logic [23:0] want;
        if (!aresetn) begin
            near_q <= NEAR_RST;
            far_q <= FAR_RST;
            curve_q <= CURVE_RST;
            atten_q <= ATTEN_RST;
            gain_q.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) gain_q.push_back(falloff_gain(s_distance));
            if (m_valid && m_ready) begin
                if (gain_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected gain item %0d", m_gain);
                end else begin
                    want = gain_q.pop_front();
                    if (want !== m_gain) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("gain mismatch: expected %0d got %0d", want, m_gain);
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_NEAR: near_q <= cfg_data;
                    CFG_FAR: far_q <= cfg_data;
                    CFG_CURVE: curve_q <= cfg_data[15:0];
                    CFG_ATTEN: atten_q <= cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

/* dv/tb.sv */
module tb;
    import dfc_pkg::*;

    localparam int PIPE_DEPTH = 26;
    localparam int STALL_LIMIT = 5000;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [1:0] cfg_index = 0;
    logic [23:0] cfg_data = 0;
    logic s_valid = 0;
    logic [23:0] s_distance = 0;
    logic m_ready = 0;
    wire s_ready, m_valid;
    wire [23:0] m_gain;
    int fail_count, pending;
    int send_gap = 0, recv_gap = 0;
    bit hold_recv = 0;
    int idle_cycles = 0;
    int sent = 0;
    logic [23:0] cur_near = NEAR_RST, cur_far = FAR_RST;

    always #5 aclk = ~aclk;

    distance_falloff_curve dut (.*);

    gain_checker chk (.*);

    always @(posedge aclk) begin
        if (hold_recv) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_gap);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic send_item(input logic [23:0] d);
        while ($urandom_range(99) < send_gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_distance <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly inside the curve span, with some near, far and any-value picks
    function automatic logic [23:0] pick_distance();
        logic [23:0] hi;
        hi = (cur_far > cur_near) ? cur_far : cur_near;
        case ($urandom_range(9))
            0: return 24'($urandom);
            1: return cur_near;
            2: return hi;
            3: return (hi == 24'hFFFFFF) ? hi : hi + 1;
            default: return 24'($urandom_range(hi, cur_near));
        endcase
    endfunction

    task automatic set_config(input logic [23:0] n, input logic [23:0] f,
                              input logic [15:0] c, input logic [23:0] a);
        write_reg(CFG_NEAR, n);
        write_reg(CFG_FAR, f);
        write_reg(CFG_CURVE, {8'd0, c});
        write_reg(CFG_ATTEN, a);
        cur_near = n;
        cur_far = f;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, region edges
        send_item(0); send_item(9216); send_item(9217); send_item(50000);
        send_item(92160); send_item(92161); send_item(24'hFFFFFF);
        end_burst();
        drain();
        // steepest curve, full range, top attenuation
        set_config(0, 24'hFFFFFF, 16'h8000, 24'hFFFFFF);
        send_item(0); send_item(1); send_item(24'h7FFFFF); send_item(24'hFFFFFE);
        send_item(24'hFFFFFF);
        end_burst();
        drain();
        // curve above one gets clamped; far below near
        set_config(1000, 2000, 16'h7FFF, 24'h123456);
        send_item(1001); send_item(1500); send_item(1999);
        end_burst();
        drain();
        set_config(5000, 100, 16'd4096, 0);
        send_item(4999); send_item(5000); send_item(5001);
        end_burst();
        drain();
        set_config(100, 101, 16'd0, 24'hFFFFFF);
        send_item(101); send_item(102);
        end_burst();
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_gap = (ph == 0) ? 13 : (ph == 1) ? 78 : 0;
            recv_gap = (ph == 0) ? 78 : (ph == 1) ? 13 : 0;
            for (int blk = 0; blk < 4; blk++) begin
                logic [23:0] n, f;
                n = $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(60000));
                f = $urandom_range(5) == 0 ? 24'($urandom) : n + 24'($urandom_range(200000));
                set_config(n, f, 16'($urandom_range(36864) - 32768), 24'($urandom));
                for (int k = 0; k < 27; k++) send_item(pick_distance());
                end_burst();
                if (ph == 2 && blk == 0) begin
                    // long receiver hold-off while the sender keeps offering items
                    fork
                        begin
                            hold_recv = 1;
                            repeat (300) @(posedge aclk);
                            hold_recv = 0;
                        end
                        for (int k = 0; k < 60; k++) send_item(pick_distance());
                    join
                    end_burst();
                end
                drain();
            end
        end

        drain();
        $display("covered %0d distances across reset, edge and random curve settings", sent);
        $display("three idling mixes plus a long output stall");
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
